// ----- rtl/cle_pkg.sv -----
package cle_pkg;

    localparam int LINE_MAX_DEF = 32;
    localparam int CMD_DEPTH    = 4;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 5;
    localparam int MAXLEN_W  = 6;
    localparam int CFG_IDX_W = 2;
    localparam int ECHO_W    = 2;

    typedef logic [BYTE_W-1:0]    byte_t;
    typedef logic [LEN_W-1:0]     len_t;
    typedef logic [MAXLEN_W-1:0]  cfg_data_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [ECHO_W-1:0]    echo_t;

    // configuration register indexes
    localparam cfg_idx_t CFG_ECHO_ENABLE = 2'd0;
    localparam cfg_idx_t CFG_EMPTY_OK    = 2'd1;
    localparam cfg_idx_t CFG_MAX_LEN     = 2'd2;

    localparam cfg_data_t MAX_LEN_RST = 6'd32;
    localparam cfg_data_t MAX_LEN_MIN = 6'd2;

    // echo work attached to a command word
    localparam echo_t ECHO_NONE  = 2'd0;
    localparam echo_t ECHO_CHAR  = 2'd1;
    localparam echo_t ECHO_ERASE = 2'd2;

    // character codes
    localparam byte_t CH_BS    = 8'd8;
    localparam byte_t CH_LF    = 8'd10;
    localparam byte_t CH_CR    = 8'd13;
    localparam byte_t CH_SP    = 8'd32;
    localparam byte_t CH_STAR  = 8'd42;
    localparam byte_t CH_DEL   = 8'd127;

    localparam logic KIND_ECHO = 1'b0;
    localparam logic KIND_LINE = 1'b1;

endpackage

// ----- rtl/cle_ram.sv -----
module cle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/cle_cmd_fifo.sv -----
module cle_cmd_fifo #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             rd,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = $clog2(DEPTH);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full  = (cnt_reg == (PW+1)'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            data_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- rtl/cle_front.sv -----
module cle_front #(
    parameter int LINE_MAX = cle_pkg::LINE_MAX_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     push,
    output logic                                     full,
    input  cle_pkg::byte_t                           rx_byte,
    input  logic                                     cfg_write,
    input  cle_pkg::cfg_idx_t                        cfg_index,
    input  cle_pkg::cfg_data_t                       cfg_data,
    input  logic                                     fifo_full,
    output logic                                     cmd_push,
    output logic [cle_pkg::ECHO_W+cle_pkg::BYTE_W+$clog2(LINE_MAX):0] cmd_word,
    output logic                                     ram_we,
    output logic [$clog2(LINE_MAX)-1:0]              ram_waddr,
    output cle_pkg::byte_t                           ram_wdata,
    input  logic                                     drain_done
);

    import cle_pkg::*;

    localparam int CW = $clog2(LINE_MAX);

    logic          echo_en_reg;
    logic          empty_ok_reg;
    cfg_data_t     max_len_reg;
    logic [CW-1:0] cursor_reg, cursor_next;
    logic          first_reg, first_next;
    logic          drain_pend_reg, drain_pend_next;

    logic          accept;
    logic          is_eol, is_erase, is_print;
    logic          done;
    echo_t         echo_code;
    byte_t         echo_byte;
    logic [CW-1:0] cur_upd;
    cfg_data_t     size_clamped, cap;

    assign full   = fifo_full || drain_pend_reg;
    assign accept = push && !full;

    assign is_eol   = (rx_byte == CH_CR) || (rx_byte == CH_LF);
    assign is_erase = (rx_byte == CH_BS) || (rx_byte == CH_DEL);
    assign is_print = !is_erase && (rx_byte >= CH_SP);

    always_comb
    begin
        if (max_len_reg < MAX_LEN_MIN)
        begin
            size_clamped = MAX_LEN_MIN;
        end
        else if (max_len_reg > MAXLEN_W'(LINE_MAX))
        begin
            size_clamped = MAXLEN_W'(LINE_MAX);
        end
        else
        begin
            size_clamped = max_len_reg;
        end
        cap = size_clamped - 1'b1;
    end

    // classify the byte and work out the new line state
    always_comb
    begin
        cur_upd   = cursor_reg;
        first_next = first_reg;
        done      = 1'b0;
        echo_code = ECHO_NONE;
        echo_byte = echo_en_reg ? rx_byte : CH_STAR;
        ram_we    = 1'b0;
        if (is_eol)
        begin
            if (!first_reg)
            begin
                first_next = 1'b1;
            end
            else if ((cursor_reg != '0) || empty_ok_reg)
            begin
                done = 1'b1;
            end
        end
        else
        begin
            first_next = 1'b1;
            if (is_erase)
            begin
                if (cursor_reg != '0)
                begin
                    cur_upd = cursor_reg - 1'b1;
                    if (echo_en_reg)
                    begin
                        echo_code = ECHO_ERASE;
                    end
                end
            end
            else if (is_print)
            begin
                if (cursor_reg < CW'(LINE_MAX-1))
                begin
                    ram_we  = accept;
                    cur_upd = cursor_reg + 1'b1;
                end
                echo_code = ECHO_CHAR;
            end
        end
        // buffer full after this byte also ends the line
        if (MAXLEN_W'(cur_upd) >= cap)
        begin
            done = 1'b1;
        end
        cursor_next = cur_upd;
        if (done)
        begin
            cursor_next = '0;
            first_next  = 1'b0;
        end
    end

    assign ram_waddr = cursor_reg;
    assign ram_wdata = rx_byte;
    assign cmd_push  = accept && ((echo_code != ECHO_NONE) || done);
    assign cmd_word  = {echo_code, echo_byte, done, cur_upd};

    always_comb
    begin
        drain_pend_next = drain_pend_reg;
        if (drain_done)
        begin
            drain_pend_next = 1'b0;
        end
        if (accept && done)
        begin
            drain_pend_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_en_reg     <= 1'b1;
            empty_ok_reg    <= 1'b0;
            max_len_reg     <= MAX_LEN_RST;
            cursor_reg      <= '0;
            first_reg       <= 1'b0;
            drain_pend_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_ECHO_ENABLE: echo_en_reg     <= cfg_data[0];
                    CFG_EMPTY_OK:    empty_ok_reg    <= cfg_data[0];
                    CFG_MAX_LEN:     max_len_reg     <= cfg_data;
                    default:         ;
                endcase
            end
            if (accept)
            begin
                cursor_reg <= cursor_next;
                first_reg  <= first_next;
            end
            drain_pend_reg <= drain_pend_next;
        end
    end

endmodule

// ----- rtl/cle_back.sv -----
module cle_back #(
    parameter int LINE_MAX = cle_pkg::LINE_MAX_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cmd_empty,
    input  logic [cle_pkg::ECHO_W+cle_pkg::BYTE_W+$clog2(LINE_MAX):0] cmd_word,
    output logic                                     cmd_pop,
    output logic                                     ram_re,
    output logic [$clog2(LINE_MAX)-1:0]              ram_raddr,
    input  cle_pkg::byte_t                           ram_rdata,
    output logic                                     drain_done,
    output logic                                     empty,
    input  logic                                     pop,
    output logic                                     kind,
    output cle_pkg::byte_t                           data_byte,
    output logic                                     line_done,
    output cle_pkg::len_t                            line_length,
    output logic                                     last
);

    import cle_pkg::*;

    localparam int CW = $clog2(LINE_MAX);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ECHO = 3'd1;
    localparam logic [2:0] S_CR   = 3'd2;
    localparam logic [2:0] S_LF   = 3'd3;
    localparam logic [2:0] S_LINE = 3'd4;

    logic [2:0]    st_reg, st_next;
    echo_t         echo_reg, echo_next;
    byte_t         ebyte_reg, ebyte_next;
    logic          done_reg, done_next;
    logic [CW-1:0] len_reg, len_next;
    logic [1:0]    eidx_reg, eidx_next;
    logic [CW-1:0] k_reg, k_next;

    logic          ov_reg, ov_next;
    logic          okind_reg;
    byte_t         obyte_reg;
    logic          oram_reg;
    logic          odone_reg;
    len_t          olen_reg;
    logic          olast_reg;

    echo_t         c_echo;
    byte_t         c_byte;
    logic          c_done;
    logic [CW-1:0] c_len;

    logic          adv, gen, g_kind, g_ram, g_last;
    byte_t         g_byte;

    assign {c_echo, c_byte, c_done, c_len} = cmd_word;
    assign adv = !ov_reg || pop;

    always_comb
    begin
        st_next    = st_reg;
        echo_next  = echo_reg;
        ebyte_next = ebyte_reg;
        done_next  = done_reg;
        len_next   = len_reg;
        eidx_next  = eidx_reg;
        k_next     = k_reg;
        cmd_pop    = 1'b0;
        gen        = 1'b0;
        g_kind     = KIND_ECHO;
        g_byte     = CH_CR;
        g_ram      = 1'b0;
        g_last     = 1'b0;
        drain_done = 1'b0;
        case (st_reg)
            S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop    = 1'b1;
                    echo_next  = c_echo;
                    ebyte_next = c_byte;
                    done_next  = c_done;
                    len_next   = c_len;
                    eidx_next  = '0;
                    if (c_echo != ECHO_NONE)
                    begin
                        st_next = S_ECHO;
                    end
                    else if (c_done)
                    begin
                        st_next = S_CR;
                    end
                end
            end
            S_ECHO:
            begin
                if (adv)
                begin
                    gen = 1'b1;
                    if (echo_reg == ECHO_CHAR)
                    begin
                        g_byte = ebyte_reg;
                    end
                    else
                    begin
                        g_byte = (eidx_reg == 2'd1) ? CH_SP : CH_BS;
                    end
                    if ((echo_reg == ECHO_CHAR) || (eidx_reg == 2'd2))
                    begin
                        g_last  = !done_reg;
                        st_next = done_reg ? S_CR : S_IDLE;
                    end
                    else
                    begin
                        eidx_next = eidx_reg + 1'b1;
                    end
                end
            end
            S_CR:
            begin
                if (adv)
                begin
                    gen     = 1'b1;
                    g_byte  = CH_CR;
                    st_next = S_LF;
                end
            end
            S_LF:
            begin
                if (adv)
                begin
                    gen    = 1'b1;
                    g_byte = CH_LF;
                    k_next = '0;
                    if (len_reg == '0)
                    begin
                        g_last     = 1'b1;
                        drain_done = 1'b1;
                        st_next    = S_IDLE;
                    end
                    else
                    begin
                        st_next = S_LINE;
                    end
                end
            end
            S_LINE:
            begin
                if (adv)
                begin
                    gen    = 1'b1;
                    g_kind = KIND_LINE;
                    g_ram  = 1'b1;
                    if (k_reg == len_reg - 1'b1)
                    begin
                        g_last     = 1'b1;
                        drain_done = 1'b1;
                        st_next    = S_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    // line bytes come from the store; the read lands with the output word
    assign ram_re    = gen && g_ram;
    assign ram_raddr = k_reg;

    always_comb
    begin
        ov_next = ov_reg;
        if (adv)
        begin
            ov_next = gen;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        echo_reg  <= echo_next;
        ebyte_reg <= ebyte_next;
        done_reg  <= done_next;
        len_reg   <= len_next;
        eidx_reg  <= eidx_next;
        k_reg     <= k_next;
        if (adv && gen)
        begin
            okind_reg <= g_kind;
            obyte_reg <= g_byte;
            oram_reg  <= g_ram;
            odone_reg <= done_reg;
            olen_reg  <= done_reg ? LEN_W'(len_reg) : '0;
            olast_reg <= g_last;
        end
    end

    assign empty       = !ov_reg;
    assign kind        = okind_reg;
    assign data_byte   = oram_reg ? ram_rdata : obyte_reg;
    assign line_done   = odone_reg;
    assign line_length = olen_reg;
    assign last        = olast_reg;

endmodule

// ----- rtl/console_line_editor.sv -----
// Console line editor: edits a line from received bytes, echoes, emits finished lines.
// A byte's first result word passes the command queue, back state and output register.
// The front takes one byte per cycle, unless full, into a 4-deep command queue; the back
// pops a command, sends all its result words (1 or 3 echo words, then CR, LF and the
// stored line) before the next, each held in the output register until it is popped.
// Reset (rst_n low, async): empty line, no command or word pending, registers at defaults.
module console_line_editor #(
    parameter int LINE_MAX = cle_pkg::LINE_MAX_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // byte input side
    input  logic               push,
    output logic               full,
    input  cle_pkg::byte_t     rx_byte,
    // result side
    output logic               empty,
    input  logic               pop,
    output logic               kind,
    output cle_pkg::byte_t     data_byte,
    output logic               line_done,
    output cle_pkg::len_t      line_length,
    output logic               last,
    // configuration writes
    input  logic               cfg_write,
    input  cle_pkg::cfg_idx_t  cfg_index,
    input  cle_pkg::cfg_data_t cfg_data
);

    import cle_pkg::*;

    // cursor width; the store holds up to LINE_MAX-1 characters
    localparam int CW    = $clog2(LINE_MAX);
    // command word: echo code, echo byte, line done, line length
    localparam int CMD_W = ECHO_W + BYTE_W + 1 + CW;

    logic             fifo_full;
    logic             fifo_empty;
    logic             cmd_push;
    logic             cmd_pop;
    logic [CMD_W-1:0] cmd_wr_word;
    logic [CMD_W-1:0] cmd_rd_word;
    logic             ram_we;
    logic [CW-1:0]    ram_waddr;
    byte_t            ram_wdata;
    logic             ram_re;
    logic [CW-1:0]    ram_raddr;
    byte_t            ram_rdata;
    logic             drain_done;

    // Front: classifies bytes, updates cursor and store, queues echo and line-end commands.
    // It holds off new bytes while a finished line is still being drained,
    // so the store is never overwritten under the back's reads.
    cle_front #(
        .LINE_MAX (LINE_MAX)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .rx_byte    (rx_byte),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fifo_full  (fifo_full),
        .cmd_push   (cmd_push),
        .cmd_word   (cmd_wr_word),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .drain_done (drain_done)
    );

    // Short command queue between front and back.
    cle_cmd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (cmd_push),
        .wdata (cmd_wr_word),
        .full  (fifo_full),
        .rd    (cmd_pop),
        .rdata (cmd_rd_word),
        .empty (fifo_empty)
    );

    // Line store: written by the front, read by the back while draining.
    cle_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (LINE_MAX)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Back: expands each command into echo words, CR LF and the line bytes,
    // through a one-word output register.
    cle_back #(
        .LINE_MAX (LINE_MAX)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_empty   (fifo_empty),
        .cmd_word    (cmd_rd_word),
        .cmd_pop     (cmd_pop),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .drain_done  (drain_done),
        .empty       (empty),
        .pop         (pop),
        .kind        (kind),
        .data_byte   (data_byte),
        .line_done   (line_done),
        .line_length (line_length),
        .last        (last)
    );

endmodule
